### sv/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
package spq_pkg;

  localparam int KEY_W   = 32;
  localparam int COUNT_W = 7;

  // Request operation codes.
  typedef enum logic [0:0] {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_t;

  // Result error codes.
  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2
  } err_t;

  // One request as it arrives on the command port.
  typedef struct packed {
    cmd_t                     command;
    logic signed [KEY_W-1:0]  key;
  } req_t;

  // One result as it leaves on the result port.
  typedef struct packed {
    logic signed [KEY_W-1:0]  smallest_key;
    logic                     is_empty;
    logic [COUNT_W-1:0]       entry_count;
    err_t                     error_code;
  } res_t;

  // Control broadcast from the top level to every cell of the row.
  typedef struct packed {
    logic                     ins;
    logic                     rem;
    logic signed [KEY_W-1:0]  key;
  } ctl_t;

endpackage

### sv/spq_cell.sv
// One cell of the sorted row: holds a single key and trades with its neighbors.
module spq_cell (
  input  logic                              clk,
  input  spq_pkg::ctl_t                     ctl,
  input  logic                              occupied,
  input  logic signed [spq_pkg::KEY_W-1:0]  left_entry,
  input  logic                              left_ge,
  input  logic signed [spq_pkg::KEY_W-1:0]  right_entry,
  output logic signed [spq_pkg::KEY_W-1:0]  entry,
  output logic                              ge
);

  // An empty cell acts as if its key were above every request key, so the
  // first empty cell is where a key lands when it is the largest so far.
  assign ge = occupied ? (entry >= ctl.key) : 1'b1;

  // On insert, cells past the landing spot take their left neighbor's key and
  // the landing cell takes the new key; on remove, every cell takes from the right.
  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (left_ge) begin
        entry <= left_entry;
      end else if (ge) begin
        entry <= ctl.key;
      end
    end else if (ctl.rem) begin
      entry <= right_entry;
    end
  end

endmodule

### sv/sorted_priority_queue_core.sv
// Top level of the sorted priority queue: a row of key cells plus the count.
// The result strobe is registered: it rises in the cycle after a request is accepted.
// Throughput: one request per cycle; every cell compares against the key in
// parallel and shifts in the same cycle, so busy is always low.
// Reset clears the entry count and the result strobe; cell keys are not reset
// and are only read below the count. The receiver cannot stall results.
module sorted_priority_queue_core #(
  parameter int CAPACITY = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  spq_pkg::req_t request,
  output logic          done,
  output spq_pkg::res_t result
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]                      count;
  logic [CW-1:0]                      count_next;
  spq_pkg::err_t                      err;
  spq_pkg::err_t                      err_next;
  logic                               accept;
  logic                               full;
  logic                               empty;
  spq_pkg::ctl_t                      ctl;
  logic signed [spq_pkg::KEY_W-1:0]   entries [CAPACITY];
  logic                               ges     [CAPACITY];

  // Every request completes in the cycle it is taken.
  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count == CW'(CAPACITY));
  assign empty  = (count == '0);

  // Request decode into the cell broadcast.
  always_comb begin
    ctl.key  = request.key;
    ctl.ins  = accept && (request.command == spq_pkg::CMD_INSERT) && !full;
    ctl.rem  = accept && (request.command == spq_pkg::CMD_REMOVE) && !empty;
    err_next = spq_pkg::ERR_NONE;
    if (accept && (request.command == spq_pkg::CMD_INSERT) && full) begin
      err_next = spq_pkg::ERR_FULL;
    end else if (accept && (request.command == spq_pkg::CMD_REMOVE) && empty) begin
      err_next = spq_pkg::ERR_EMPTY;
    end
    count_next = count;
    if (ctl.ins) begin
      count_next = count + 1'b1;
    end else if (ctl.rem) begin
      count_next = count - 1'b1;
    end
  end

  // Count, error code and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
      err   <= spq_pkg::ERR_NONE;
    end else begin
      count <= count_next;
      done  <= accept;
      err   <= err_next;
    end
  end

  // The row of cells, smallest key in cell zero.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [spq_pkg::KEY_W-1:0] left_entry;
    logic                             left_ge;
    logic signed [spq_pkg::KEY_W-1:0] right_entry;

    if (i == 0) begin : g_first
      assign left_entry = request.key;
      assign left_ge    = 1'b0;
    end else begin : g_inner
      assign left_entry = entries[i-1];
      assign left_ge    = ges[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_entry = entries[i];
    end else begin : g_body
      assign right_entry = entries[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occupied    (count > CW'(i)),
      .left_entry  (left_entry),
      .left_ge     (left_ge),
      .right_entry (right_entry),
      .entry       (entries[i]),
      .ge          (ges[i])
    );
  end

  // Result fields come straight from the updated state.
  always_comb begin
    result.smallest_key = empty ? '0 : entries[0];
    result.is_empty     = empty;
    result.entry_count  = spq_pkg::COUNT_W'(count);
    result.error_code   = err;
  end

  // The count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // A legal insert grows the count by exactly one.
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    ctl.ins |=> count == $past(count) + 1'b1)
    else $error("insert did not grow the count");

  // An overflow report means the queue is still full.
  a_full_report: assert property (@(posedge clk) disable iff (rst)
    done && (result.error_code == spq_pkg::ERR_FULL) |-> full)
    else $error("overflow reported while not full");

  // The two smallest stored keys stay in order.
  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    count >= CW'(2) |-> entries[0] <= entries[1])
    else $error("head of the row out of order");

  // One result strobe for each accepted request.
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> done == $past(accept))
    else $error("result strobe does not match accepted request");

endmodule
